// File: sv/fskd_pkg.sv
// Shared types, constants and the sine table builder for the FSK tone discriminator.
`default_nettype none
package fskd_pkg;

  localparam int MAX_WINDOW_DEF  = 256;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_N          = 1 << SINE_TABLE_BITS;
  localparam int SINE_QUARTER    = SINE_N >> 2;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  localparam int PHASE_W = 24;
  localparam int SCALE_W = 41;
  localparam int WLEN_W  = 9;
  localparam int CFG_W   = 41;
  localparam int IDX_W   = 3;
  localparam int ACC_W   = 40;
  localparam int PROD_W  = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W  = 1;

  localparam logic [PHASE_W-1:0] MODULUS_RST    = 24'd48000;
  localparam logic [PHASE_W-1:0] MARK_STEP_RST  = 24'd1200;
  localparam logic [PHASE_W-1:0] SPACE_STEP_RST = 24'd2200;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 41'd22906492;
  localparam logic [WLEN_W-1:0]  WLEN_RST       = 9'd40;

  typedef enum logic [IDX_W-1:0] {
    REG_MODULUS    = 3'd0,
    REG_MARK_STEP  = 3'd1,
    REG_SPACE_STEP = 3'd2,
    REG_SCALE      = 3'd3,
    REG_WINDOW     = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    F_IDLE, F_REDUCE, F_MIX, F_ACCUM, F_SEND
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_NORM, B_SQUARE, B_DIFF, B_NUMER, B_DIV, B_DONE
  } back_state_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] m_re;
    logic signed [ACC_W-1:0] m_im;
    logic signed [ACC_W-1:0] s_re;
    logic signed [ACC_W-1:0] s_im;
  } acc_set_t;

  typedef logic signed [15:0] sine_tab_t [SINE_N];

  // shift-and-subtract quotient, evaluated only while the table is built
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo, rmd;
    quo = 0;
    rmd = 0;
    for (int b = 63; b >= 0; b--) begin
      rmd = {rmd[62:0], num[b]};
      if (rmd >= den) begin
        rmd    = rmd - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic signed [15:0] quarter_sine(input int k);
    longint unsigned x, x2, term, den;
    longint sum;
    int n;
    x = (TWO_PI_Q30 * longint'(k) + longint'(SINE_N >> 1)) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    sum = longint'(x);
    term = x;
    for (n = 1; n <= 20; n++) begin
      if (term != 0) begin
        den = longint'((2 * n) * (2 * n + 1));
        term = div_u64((term * x2) >> 30, den);
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
    end
    if (sum < 0) sum = 0;
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) sum = 32767;
    return 16'(sum);
  endfunction

  function automatic sine_tab_t build_sine_table();
    sine_tab_t t;
    int q, r;
    logic signed [15:0] v;
    for (int i = 0; i < SINE_N; i++) begin
      q = i / SINE_QUARTER;
      r = i % SINE_QUARTER;
      v = (q % 2 == 1) ? quarter_sine(SINE_QUARTER - r) : quarter_sine(r);
      t[i] = (q >= 2) ? -v : v;
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// File: sv/fsk_tone_discriminator_top.sv
// Top level of the FSK tone discriminator: front end, sum queue and ratio back end.
// The back end's normalizing shifts and its bit-per-cycle divider set the pace of results; the divider
// is skipped when all sums are zero. A write to the modulus or a step adds operand reduction before
// the next sample is mixed. The front end can take a new sample while the back end is still busy
// with earlier sums, until the sum queue is full.
// Reset: synchronous; registers return to defaults, sums and phases clear, ring reads as zero.
`default_nettype none
module fsk_tone_discriminator_top #(
  parameter int MAX_WINDOW = fskd_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [fskd_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [fskd_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic signed [15:0]          sample,
  output logic                             empty,
  input  wire logic                        pop,
  output logic signed [15:0]               soft_value
);
  import fskd_pkg::*;

  acc_set_t push_data, pop_data;
  logic     q_push, q_full, q_pop, q_empty;

  fskd_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .push, .full, .sample,
    .q_push, .q_data(push_data), .q_full
  );

  fskd_queue u_queue (
    .clk, .rst,
    .push(q_push), .push_data, .full(q_full),
    .pop(q_pop), .pop_data, .empty(q_empty)
  );

  fskd_back u_back (
    .clk, .rst,
    .q_data(pop_data), .q_empty, .q_pop,
    .empty, .pop, .soft_value
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> full) else $error("front end not busy after input transfer");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("back end popped an empty queue");

  a_no_push_when_idle: assert property (@(posedge clk) disable iff (rst)
    q_push |-> full) else $error("queue push while front end idle");

endmodule
`default_nettype wire

// File: sv/fskd_queue.sv
// Short FIFO of running sums between the mixing front end and the ratio back end.
`default_nettype none
module fskd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire fskd_pkg::acc_set_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output fskd_pkg::acc_set_t     pop_data,
  output logic                   empty
);
  import fskd_pkg::*;

  acc_set_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: sv/fskd_front.sv
// Front end: configuration, phase counters, tone mixing and boxcar running sums.
`default_nettype none
module fskd_front #(
  parameter int MAX_WINDOW = fskd_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [fskd_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [fskd_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic signed [15:0]          sample,
  output logic                             q_push,
  output fskd_pkg::acc_set_t               q_data,
  input  wire logic                        q_full
);
  import fskd_pkg::*;

  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int B      = SINE_TABLE_BITS;
  localparam logic [39:0] HALF = 40'd1 << (39 - B);
  localparam sine_tab_t SINE_TAB = build_sine_table();

  front_state_t state, state_next;

  logic [PHASE_W-1:0] modulus, mark_step, space_step;
  logic [SCALE_W-1:0] scale;
  logic [WLEN_W-1:0]  wlen;
  logic               dirty;
  logic [PHASE_W-1:0] mark_step_r, space_step_r;
  logic [PHASE_W-1:0] mark_phase, space_phase;

  logic [SLOT_W-1:0]  slot, slot_cur;
  logic [MAX_WINDOW-1:0] valid;
  logic [127:0]       ring [MAX_WINDOW];
  logic [127:0]       ring_q;

  logic signed [15:0] x;
  logic [2:0]         step;
  logic [1:0]         opn;
  logic [4:0]         bitc;
  logic [PHASE_W:0]   rem;
  logic [PHASE_W:0]   rem_shift;
  logic [PHASE_W:0]   rem_next;
  logic [PHASE_W-1:0] operand;
  logic [PHASE_W:0]   mod25;

  logic [43:0]        p_lo, p_hi;
  logic [PHASE_W-1:0] ph_sel;
  logic [39:0]        idx_sum;
  logic [B-1:0]       idx_m, idx_s, rom_addr;
  logic signed [15:0] rom_q;
  logic signed [PROD_W-1:0] m_re, m_im, s_re, s_im;
  logic signed [PROD_W-1:0] new_m_im, new_s_im;
  logic [127:0]       new_word, old_word;

  logic signed [ACC_W-1:0] acc_m_re, acc_m_im, acc_s_re, acc_s_im;

  logic [WIN_W-1:0]   win;
  logic [WIN_W-1:0]   slot_ext;
  logic [WIN_W-1:0]   slot_inc;
  logic [PHASE_W:0]   mark_sum, space_sum;

  function automatic logic signed [ACC_W-1:0] sx(input logic [PROD_W-1:0] v);
    return {{(ACC_W-PROD_W){v[PROD_W-1]}}, v};
  endfunction

  // effective window and slot arithmetic
  always_comb begin
    if (wlen == '0) win = WIN_W'(1);
    else if (32'(wlen) > MAX_WINDOW) win = WIN_W'(MAX_WINDOW);
    else win = WIN_W'(wlen);
    slot_ext = WIN_W'(slot);
    slot_inc = WIN_W'(slot_cur) + 1'b1;
  end

  assign mod25 = (modulus == '0) ? (PHASE_W+1)'(1 << PHASE_W) : {1'b0, modulus};

  // remainder unit, one dividend bit per cycle
  always_comb begin
    case (opn)
      2'd0:    operand = mark_phase;
      2'd1:    operand = space_phase;
      2'd2:    operand = mark_step;
      default: operand = space_step;
    endcase
    rem_shift = {rem[PHASE_W-1:0], operand[5'd23 - bitc]};
    rem_next  = (rem_shift >= mod25) ? rem_shift - mod25 : rem_shift;
  end

  assign ph_sel  = (step == 3'd0) ? mark_phase : space_phase;
  assign idx_sum = p_lo[39:0] + {p_hi[19:0], 20'd0} + HALF;

  always_comb begin
    case (step)
      3'd2:    rom_addr = idx_m + B'(SINE_QUARTER);
      3'd3:    rom_addr = idx_m;
      3'd4:    rom_addr = idx_s + B'(SINE_QUARTER);
      3'd5:    rom_addr = idx_s;
      default: rom_addr = idx_m;
    endcase
  end

  assign new_m_im = -m_im;
  assign new_s_im = -s_im;
  assign new_word = {m_re, new_m_im, s_re, new_s_im};
  assign old_word = valid[slot_cur] ? ring_q : '0;
  assign mark_sum  = {1'b0, mark_phase} + {1'b0, mark_step_r};
  assign space_sum = {1'b0, space_phase} + {1'b0, space_step_r};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:   if (push) state_next = dirty ? F_REDUCE : F_MIX;
      F_REDUCE: if (opn == 2'd3 && bitc == 5'd23) state_next = F_MIX;
      F_MIX:    if (step == 3'd6) state_next = F_ACCUM;
      F_ACCUM:  state_next = F_SEND;
      F_SEND:   if (!q_full) state_next = F_IDLE;
      default:  state_next = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full   = (state != F_IDLE);
    q_push = (state == F_SEND);
    q_data = '{m_re: acc_m_re, m_im: acc_m_im, s_re: acc_s_re, s_im: acc_s_im};
  end

  always_ff @(posedge clk) begin
    rom_q  <= SINE_TAB[rom_addr];
    ring_q <= ring[slot_cur];
    p_lo   <= ph_sel * scale[19:0];
    p_hi   <= ph_sel * scale[39:20];
    if (state == F_ACCUM) begin
      ring[slot_cur] <= new_word;
    end
    if (state == F_IDLE && push) begin
      x        <= sample;
      slot_cur <= (slot_ext >= win) ? '0 : slot;
    end
    if (state == F_MIX) begin
      case (step)
        3'd1:    idx_m <= idx_sum[39 -: B];
        3'd2:    idx_s <= idx_sum[39 -: B];
        3'd3:    m_re  <= x * rom_q;
        3'd4:    m_im  <= x * rom_q;
        3'd5:    s_re  <= x * rom_q;
        3'd6:    s_im  <= x * rom_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      modulus      <= MODULUS_RST;
      mark_step    <= MARK_STEP_RST;
      space_step   <= SPACE_STEP_RST;
      scale        <= SCALE_RST;
      wlen         <= WLEN_RST;
      dirty        <= 1'b0;
      mark_step_r  <= MARK_STEP_RST;
      space_step_r <= SPACE_STEP_RST;
      mark_phase   <= '0;
      space_phase  <= '0;
      slot         <= '0;
      valid        <= '0;
      acc_m_re     <= '0;
      acc_m_im     <= '0;
      acc_s_re     <= '0;
      acc_s_im     <= '0;
      step         <= '0;
      opn          <= '0;
      bitc         <= '0;
      rem          <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_MODULUS: begin
            modulus <= cfg_data[PHASE_W-1:0];
            dirty   <= 1'b1;
          end
          REG_MARK_STEP: begin
            mark_step <= cfg_data[PHASE_W-1:0];
            dirty     <= 1'b1;
          end
          REG_SPACE_STEP: begin
            space_step <= cfg_data[PHASE_W-1:0];
            dirty      <= 1'b1;
          end
          REG_SCALE: scale <= cfg_data[SCALE_W-1:0];
          REG_WINDOW: begin
            wlen     <= cfg_data[WLEN_W-1:0];
            valid    <= '0;
            slot     <= '0;
            acc_m_re <= '0;
            acc_m_im <= '0;
            acc_s_re <= '0;
            acc_s_im <= '0;
          end
          default: ;
        endcase
      end
      case (state)
        F_IDLE: begin
          step <= '0;
          opn  <= '0;
          bitc <= '0;
          rem  <= '0;
        end
        F_REDUCE: begin
          if (bitc == 5'd23) begin
            rem  <= '0;
            bitc <= '0;
            opn  <= opn + 1'b1;
            case (opn)
              2'd0:    mark_phase   <= rem_next[PHASE_W-1:0];
              2'd1:    space_phase  <= rem_next[PHASE_W-1:0];
              2'd2:    mark_step_r  <= rem_next[PHASE_W-1:0];
              default: begin
                space_step_r <= rem_next[PHASE_W-1:0];
                dirty        <= 1'b0;
              end
            endcase
          end else begin
            rem  <= rem_next;
            bitc <= bitc + 1'b1;
          end
        end
        F_MIX: step <= step + 1'b1;
        F_ACCUM: begin
          acc_m_re <= acc_m_re + sx(m_re)     - sx(old_word[127:96]);
          acc_m_im <= acc_m_im + sx(new_m_im) - sx(old_word[95:64]);
          acc_s_re <= acc_s_re + sx(s_re)     - sx(old_word[63:32]);
          acc_s_im <= acc_s_im + sx(new_s_im) - sx(old_word[31:0]);
          valid[slot_cur] <= 1'b1;
          slot <= (slot_inc >= win) ? '0 : SLOT_W'(slot_inc);
          mark_phase  <= (mark_sum >= mod25) ? PHASE_W'(mark_sum - mod25)
                                             : mark_sum[PHASE_W-1:0];
          space_phase <= (space_sum >= mod25) ? PHASE_W'(space_sum - mod25)
                                              : space_sum[PHASE_W-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/fskd_back.sv
// Back end: power of both tones, normalized difference ratio and result register.
`default_nettype none
module fskd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fskd_pkg::acc_set_t q_data,
  input  wire logic               q_empty,
  output logic                    q_pop,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      soft_value
);
  import fskd_pkg::*;

  back_state_t state, state_next;

  logic [ACC_W-1:0] a [4];
  logic [2:0]       cnt;
  logic [45:0]      sq;
  logic [46:0]      pm, ps;
  logic [47:0]      total;
  logic [46:0]      d;
  logic             neg;
  logic [62:0]      numer;
  logic [47:0]      rem;
  logic [48:0]      rem_shift;
  logic [15:0]      numlo;
  logic [15:0]      q;
  logic [3:0]       bitc;
  logic             out_valid;
  logic signed [15:0] res;
  logic             too_big;

  function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? ACC_W'(-v) : v;
  endfunction

  assign too_big = (|a[0][ACC_W-1:23]) || (|a[1][ACC_W-1:23]) ||
                   (|a[2][ACC_W-1:23]) || (|a[3][ACC_W-1:23]);
  assign numer     = {d, 15'd0} + 63'(total >> 1);
  assign rem_shift = {rem, numlo[bitc]};

  always_comb begin
    if (neg) res = -$signed(q);
    else if (q > 16'd32767) res = 16'sd32767;
    else res = $signed(q);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:   if (!q_empty) state_next = B_NORM;
      B_NORM:   if (!too_big) state_next = B_SQUARE;
      B_SQUARE: if (cnt == 3'd4) state_next = B_DIFF;
      B_DIFF:   state_next = B_NUMER;
      B_NUMER:  state_next = (total == '0) ? B_DONE : B_DIV;
      B_DIV:    if (bitc == 4'd0) state_next = B_DONE;
      B_DONE:   if (!out_valid || pop) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop = (state == B_IDLE) && !q_empty;
    empty = !out_valid;
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        a[0] <= mag(q_data.m_re);
        a[1] <= mag(q_data.m_im);
        a[2] <= mag(q_data.s_re);
        a[3] <= mag(q_data.s_im);
        pm   <= '0;
        ps   <= '0;
      end
      B_NORM: begin
        if (too_big) begin
          for (int i = 0; i < 4; i++) a[i] <= a[i] >> 1;
        end
      end
      B_SQUARE: begin
        if (cnt != 3'd4) sq <= a[cnt[1:0]][22:0] * a[cnt[1:0]][22:0];
        if (cnt == 3'd1 || cnt == 3'd2) pm <= pm + 47'(sq);
        if (cnt == 3'd3 || cnt == 3'd4) ps <= ps + 47'(sq);
      end
      B_DIFF: begin
        total <= 48'(pm) + 48'(ps);
        neg   <= (ps > pm);
        d     <= (ps > pm) ? ps - pm : pm - ps;
      end
      B_NUMER: begin
        rem   <= 48'(numer >> 16);
        numlo <= numer[15:0];
        q     <= '0;
      end
      B_DIV: begin
        if (rem_shift >= {1'b0, total}) begin
          rem     <= 48'(rem_shift - {1'b0, total});
          q[bitc] <= 1'b1;
        end else begin
          rem <= rem_shift[47:0];
        end
      end
      default: ;
    endcase
    if (state == B_DONE && (!out_valid || pop)) soft_value <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      bitc      <= '0;
    end else begin
      state <= state_next;
      if (state == B_DONE && (!out_valid || pop)) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (state == B_SQUARE) cnt <= cnt + 1'b1;
      else cnt <= '0;
      if (state == B_DIV) bitc <= bitc - 1'b1;
      else bitc <= 4'd15;
    end
  end

endmodule
`default_nettype wire

// File: test/fsk_tone_discriminator_top_tb.sv
// Self-checking testbench for the FSK tone discriminator top level.
`timescale 1ns / 100ps
module fsk_tone_discriminator_top_tb;
  import fskd_pkg::*;

  localparam int WDOG_LIMIT = 20000;
  localparam int TAB_SIZE = 1024;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic signed [15:0] sample = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] soft_value;

  fsk_tone_discriminator_top uut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .push(push), .full(full), .sample(sample),
    .empty(empty), .pop(pop), .soft_value(soft_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  int sin_lut [TAB_SIZE];
  longint unsigned rate_r, mstep_r, sstep_r, scale_r, wlen_r;
  int mark_ring_re [256], mark_ring_im [256], space_ring_re [256], space_ring_im [256];
  longint m_re_sum, m_im_sum, s_re_sum, s_im_sum;
  int slot;
  longint unsigned m_phase, s_phase;

  logic signed [15:0] sample_queue [$];
  logic signed [15:0] soft_queue [$];
  int send_idle = 0, recv_idle = 0;
  int errors = 0;
  int wdog = 0;

  function automatic int quarter_wave(int k);
    longint unsigned x, x2, term;
    longint acc;
    x = (64'd6746518852 * longint'(k) + 512) >> 10;
    x2 = (x * x) >> 30;
    acc = longint'(x);
    term = x;
    for (int n = 1; n <= 20 && term != 0; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 16384) >>> 15;
    return acc > 32767 ? 32767 : int'(acc);
  endfunction

  function automatic void clear_rings();
    for (int i = 0; i < 256; i++) begin
      mark_ring_re[i] = 0; mark_ring_im[i] = 0;
      space_ring_re[i] = 0; space_ring_im[i] = 0;
    end
    m_re_sum = 0; m_im_sum = 0; s_re_sum = 0; s_im_sum = 0;
    slot = 0;
  endfunction

  function automatic void tone_mix(int x, longint unsigned ph, output int re, output int im);
    logic [63:0] pr;
    int idx;
    pr = 64'(ph) * 64'(scale_r);
    idx = int'(((pr + (64'd1 << 29)) >> 30) & 64'd1023);
    re = x * sin_lut[(idx + 256) % TAB_SIZE];
    im = -(x * sin_lut[idx]);
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic logic signed [15:0] discriminate(logic signed [15:0] smp);
    longint unsigned md, win, mp, sp, maxv, pm, ps, tot, d, q;
    longint unsigned a [4];
    longint diff;
    int mre, mim, sre, sim, sh;
    md = rate_r == 0 ? 64'd1 << 24 : rate_r;
    win = wlen_r == 0 ? 1 : (wlen_r > 256 ? 256 : wlen_r);
    mp = m_phase % md;
    sp = s_phase % md;
    if (slot >= win) slot = 0;
    tone_mix(int'(smp), mp, mre, mim);
    tone_mix(int'(smp), sp, sre, sim);
    m_re_sum += longint'(mre) - mark_ring_re[slot];
    m_im_sum += longint'(mim) - mark_ring_im[slot];
    s_re_sum += longint'(sre) - space_ring_re[slot];
    s_im_sum += longint'(sim) - space_ring_im[slot];
    mark_ring_re[slot] = mre; mark_ring_im[slot] = mim;
    space_ring_re[slot] = sre; space_ring_im[slot] = sim;
    slot = (slot + 1 >= win) ? 0 : slot + 1;
    m_phase = (mp + mstep_r % md) % md;
    s_phase = (sp + sstep_r % md) % md;
    a[0] = absval(m_re_sum); a[1] = absval(m_im_sum);
    a[2] = absval(s_re_sum); a[3] = absval(s_im_sum);
    maxv = 0;
    for (int i = 0; i < 4; i++) if (a[i] > maxv) maxv = a[i];
    sh = 0;
    while (maxv >= (64'd1 << 23)) begin
      maxv >>= 1;
      sh++;
    end
    for (int i = 0; i < 4; i++) a[i] >>= sh;
    pm = a[0] * a[0] + a[1] * a[1];
    ps = a[2] * a[2] + a[3] * a[3];
    tot = pm + ps;
    if (tot == 0) return 16'sd0;
    diff = longint'(pm) - longint'(ps);
    d = absval(diff);
    q = (d * 32768 + tot / 2) / tot;
    if (diff < 0) return 16'(-longint'(q > 32768 ? 32768 : q));
    return 16'(q > 32767 ? 32767 : q);
  endfunction

  task automatic report(string what, logic signed [15:0] got, logic signed [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MODULUS: rate_r = val[23:0];
      REG_MARK_STEP: mstep_r = val[23:0];
      REG_SPACE_STEP: sstep_r = val[23:0];
      REG_SCALE: scale_r = val[40:0];
      REG_WINDOW: begin
        wlen_r = val[8:0];
        clear_rings();
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (sample_queue.size() != 0 || soft_queue.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        soft_queue = {soft_queue, discriminate(sample)};
        void'(sample_queue.pop_front());
      end
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
        push <= 1'b1;
        sample <= sample_queue[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (soft_queue.size() == 0) report("unexpected transfer", soft_value, 16'sd0);
        else begin
          if (soft_value !== soft_queue[0]) report("soft_value", soft_value, soft_queue[0]);
          void'(soft_queue.pop_front());
        end
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] scale_for(longint unsigned md);
    longint unsigned m;
    m = md == 0 ? 64'd1 << 24 : md;
    return CFG_W'(((64'd1 << 40) + m / 2) / m);
  endfunction

  initial begin
    longint unsigned md;
    for (int i = 0; i < TAB_SIZE; i++) begin
      int qd, r, v;
      qd = i / 256;
      r = i % 256;
      v = (qd % 2 == 1) ? quarter_wave(256 - r) : quarter_wave(r);
      sin_lut[i] = (qd >= 2) ? -v : v;
    end
    rate_r = 48000; mstep_r = 1200; sstep_r = 2200; scale_r = 22906492; wlen_r = 40;
    clear_rings();
    m_phase = 0; s_phase = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: silence, extremes, defaults
    for (int i = 0; i < 4; i++) sample_queue = {sample_queue, 16'sd0};
    sample_queue = {sample_queue, -16'sd32768};
    sample_queue = {sample_queue, 16'sd32767};
    for (int i = 0; i < 6; i++)
      sample_queue = {sample_queue, (i % 2 ? -16'sd32768 : 16'sd32767)};
    drain();
    // zero modulus, maximum and mid-range steps, window zero, full-scale phase scale
    write_reg(REG_MODULUS, '0);
    write_reg(REG_MARK_STEP, 41'hFFFFFF);
    write_reg(REG_SPACE_STEP, 41'h123456);
    write_reg(REG_SCALE, 41'd1 << 40);
    write_reg(REG_WINDOW, '0);
    for (int i = 0; i < 5; i++) sample_queue = {sample_queue, rand_sample()};
    drain();
    write_reg(REG_MODULUS, 41'd1);
    write_reg(REG_SCALE, '0);
    write_reg(REG_WINDOW, 41'd511);
    for (int i = 0; i < 6; i++) sample_queue = {sample_queue, rand_sample()};
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_idle = 0; end
        1: begin send_idle = 59; recv_idle = 0; end
        2: begin send_idle = 0; recv_idle = 59; end
        default: begin send_idle = 26; recv_idle = 26; end
      endcase
      case ($urandom_range(4))
        0: md = 48000;
        1: md = 8000;
        2: md = 0;
        3: md = $urandom_range(16777215, 1);
        default: md = $urandom_range(2000, 1);
      endcase
      write_reg(REG_MODULUS, CFG_W'(md));
      write_reg(REG_MARK_STEP, CFG_W'($urandom_range(15) == 0 ? $urandom_range(16777215)
                               : $urandom_range(md == 0 ? 16777215 : md - 1)));
      write_reg(REG_SPACE_STEP, CFG_W'($urandom_range(15) == 0 ? $urandom_range(16777215)
                                : $urandom_range(md == 0 ? 16777215 : md - 1)));
      write_reg(REG_SCALE, $urandom_range(5) == 0 ? CFG_W'({$urandom, $urandom})
                                                  : scale_for(md));
      case ($urandom_range(5))
        0: write_reg(REG_WINDOW, 41'd1);
        1: write_reg(REG_WINDOW, 41'd256);
        2: write_reg(REG_WINDOW, CFG_W'($urandom_range(511)));
        default: write_reg(REG_WINDOW, CFG_W'($urandom_range(64, 1)));
      endcase
      for (int i = 0; i < 120; i++) sample_queue = {sample_queue, rand_sample()};
      drain();
    end

    if (errors == 0 && soft_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
